// File: rtl/mffd_pkg.sv
// Shared types and constants of the motor feedback frame decoder.
`default_nettype none

package mffd_pkg;

   // Default number of motors held in the feedback store
   localparam int MOTOR_COUNT_DEF = 4;

   // Frame layout
   localparam logic [3:0] FRAME_LEN  = 4'd11;
   localparam logic [3:0] FRAME_LAST = 4'd10;
   localparam logic [7:0] PREAMBLE_0 = 8'hD5;
   localparam logic [7:0] PREAMBLE_1 = 8'hE5;

   // Command codes
   localparam logic [7:0] CMD_SPEED  = 8'h02;
   localparam logic [7:0] CMD_STATUS = 8'h06;
   localparam logic [7:0] CMD_TICKS  = 8'h00;

   // Result kinds
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   // Frame verdict codes
   localparam logic [2:0] ST_APPLIED   = 3'd0;
   localparam logic [2:0] ST_IGNORED   = 3'd1;
   localparam logic [2:0] ST_PREAMBLE  = 3'd2;
   localparam logic [2:0] ST_CHECKSUM  = 3'd3;
   localparam logic [2:0] ST_MOTOR_ID  = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
      logic       frame_start;
      logic [1:0] motor_sel;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [2:0]         frame_status;
      logic [7:0]         motor_id;
      logic [7:0]         command;
      logic signed [15:0] speed;
      logic [15:0]        current;
      logic [7:0]         status_byte;
      logic [7:0]         flags_byte;
      logic signed [31:0] ticks;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/motor_feedback_frame_decoder_top.sv
// Top level of the motor feedback frame decoder: byte capture, verdict and feedback store.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | mffd_pkg::req_type
//  rsp     | out       | rsp_valid / rsp_stall  | mffd_pkg::rsp_type
//
// One item a cycle sustained while rsp is not stalled; a transfer loads the input register,
// the result register loads next, and the result can then transfer on rsp.
// The frame check, store update and store read all sit between those two registers.
// A stalled rsp holds the result register and, while it holds an item, the input register.
// Synchronous reset clears byte position, running sum and the whole feedback store.
`default_nettype none

module motor_feedback_frame_decoder_top #(
   parameter int MOTOR_COUNT = mffd_pkg::MOTOR_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mffd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mffd_pkg::rsp_type      rsp_data
);

   localparam int         ID_W   = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam logic [8:0] COUNT9 = 9'(MOTOR_COUNT);

   // Input register
   logic              req_valid_ff;
   mffd_pkg::req_type req_data_ff;

   // Frame capture state
   logic [3:0] pos_ff, pos_in;
   logic [7:0] frame_ff [0:9];
   logic [7:0] frame_in [0:9];
   logic [6:0] sum_ff, sum_in;

   // Feedback store
   logic [15:0] speed_ff   [0:MOTOR_COUNT-1];
   logic [15:0] current_ff [0:MOTOR_COUNT-1];
   logic [7:0]  status_ff  [0:MOTOR_COUNT-1];
   logic [7:0]  flags_ff   [0:MOTOR_COUNT-1];
   logic [31:0] ticks_ff   [0:MOTOR_COUNT-1];

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   mffd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Work signals
   logic            out_free;
   logic            go;
   logic [3:0]      pos;
   logic            last;
   logic [6:0]      sum_fin;
   logic [7:0]      addr8;
   logic            in_range;
   logic [ID_W-1:0] idx;
   logic [15:0]     new_speed, new_current;
   logic [7:0]      new_status, new_flags;
   logic [31:0]     new_ticks;
   logic            wr_speed, wr_current, wr_sf, wr_ticks;
   logic [2:0]      verdict;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go        = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Resolve byte position of the held item
   always_comb begin
      pos = req_data_ff.frame_start ? 4'd0 : pos_ff;
      if (pos >= mffd_pkg::FRAME_LEN) begin
         pos = 4'd0;
      end
      last    = (pos == mffd_pkg::FRAME_LAST);
      sum_fin = sum_ff + req_data_ff.rx_byte[6:0];
   end

   // Pick the store entry: frame motor id or read selector
   always_comb begin
      addr8    = (req_data_ff.kind == mffd_pkg::KIND_READ) ?
                 {6'd0, req_data_ff.motor_sel} : frame_ff[2];
      in_range = ({1'b0, addr8} < COUNT9);
      idx      = addr8[ID_W-1:0];
   end

   // Judge the frame and form the updated feedback of the addressed motor
   always_comb begin
      wr_speed   = 1'b0;
      wr_current = 1'b0;
      wr_sf      = 1'b0;
      wr_ticks   = 1'b0;
      if (in_range) begin
         new_speed   = speed_ff[idx];
         new_current = current_ff[idx];
         new_status  = status_ff[idx];
         new_flags   = flags_ff[idx];
         new_ticks   = ticks_ff[idx];
      end else begin
         new_speed   = '0;
         new_current = '0;
         new_status  = '0;
         new_flags   = '0;
         new_ticks   = '0;
      end

      if (frame_ff[0] != mffd_pkg::PREAMBLE_0 || frame_ff[1] != mffd_pkg::PREAMBLE_1) begin
         verdict = mffd_pkg::ST_PREAMBLE;
      end else if ({1'b0, sum_fin} != frame_ff[6]) begin
         verdict = mffd_pkg::ST_CHECKSUM;
      end else if (!in_range) begin
         verdict = mffd_pkg::ST_MOTOR_ID;
      end else if (req_data_ff.kind == mffd_pkg::KIND_READ) begin
         // A read returns the entry as stored
         verdict = mffd_pkg::ST_APPLIED;
      end else begin
         unique case (frame_ff[4])
            mffd_pkg::CMD_SPEED: begin
               verdict    = mffd_pkg::ST_APPLIED;
               wr_speed   = 1'b1;
               wr_current = 1'b1;
               wr_sf      = 1'b1;
               new_speed   = {frame_ff[7], frame_ff[9]};
               new_current = {frame_ff[3], frame_ff[5]};
               new_status  = req_data_ff.rx_byte;
               new_flags   = frame_ff[8];
            end
            mffd_pkg::CMD_STATUS: begin
               verdict    = mffd_pkg::ST_APPLIED;
               wr_speed   = 1'b1;
               wr_sf      = 1'b1;
               new_speed  = '0;
               new_status = req_data_ff.rx_byte;
               new_flags  = frame_ff[8];
            end
            mffd_pkg::CMD_TICKS: begin
               verdict   = mffd_pkg::ST_APPLIED;
               wr_ticks  = 1'b1;
               new_ticks = {frame_ff[3], frame_ff[5], frame_ff[7], frame_ff[9]};
            end
            default: begin
               verdict = mffd_pkg::ST_IGNORED;
            end
         endcase
      end
   end

   // Next state of capture and result register
   always_comb begin
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (go) begin
         if (req_data_ff.kind == mffd_pkg::KIND_READ) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_kind  = mffd_pkg::KIND_READ;
            rsp_data_in.frame_status = mffd_pkg::ST_APPLIED;
            rsp_data_in.motor_id     = addr8;
            rsp_data_in.command      = '0;
            rsp_data_in.speed        = new_speed;
            rsp_data_in.current      = new_current;
            rsp_data_in.status_byte  = new_status;
            rsp_data_in.flags_byte   = new_flags;
            rsp_data_in.ticks        = new_ticks;
         end else if (last) begin
            pos_in                   = 4'd0;
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_kind  = mffd_pkg::KIND_FRAME;
            rsp_data_in.frame_status = verdict;
            rsp_data_in.motor_id     = frame_ff[2];
            rsp_data_in.command      = frame_ff[4];
            rsp_data_in.speed        = new_speed;
            rsp_data_in.current      = new_current;
            rsp_data_in.status_byte  = new_status;
            rsp_data_in.flags_byte   = new_flags;
            rsp_data_in.ticks        = new_ticks;
         end else begin
            pos_in        = pos + 4'd1;
            frame_in[pos] = req_data_ff.rx_byte;
            // Accumulate the 7-bit sum over payload bytes, skipping the check byte
            case (pos)
               4'd0, 4'd1: sum_in = '0;
               4'd6:       sum_in = sum_ff;
               default:    sum_in = sum_fin;
            endcase
         end
      end
   end

   // Hold control state, capture and store
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         sum_ff       <= '0;
         for (int i = 0; i < 10; i++) begin
            frame_ff[i] <= '0;
         end
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            speed_ff[m]   <= '0;
            current_ff[m] <= '0;
            status_ff[m]  <= '0;
            flags_ff[m]   <= '0;
            ticks_ff[m]   <= '0;
         end
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         frame_ff     <= frame_in;
         if (go && req_data_ff.kind == mffd_pkg::KIND_FRAME && last) begin
            if (wr_speed) begin
               speed_ff[idx] <= new_speed;
            end
            if (wr_current) begin
               current_ff[idx] <= new_current;
            end
            if (wr_sf) begin
               status_ff[idx] <= new_status;
               flags_ff[idx]  <= new_flags;
            end
            if (wr_ticks) begin
               ticks_ff[idx] <= new_ticks;
            end
         end
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// File: verif/tb_motor_feedback_frame_decoder_top.sv
// Testbench for the motor feedback frame decoder: frame and read traffic checked against a predictor.
module tb_motor_feedback_frame_decoder_top;

   localparam int NUM_MOTORS  = mffd_pkg::MOTOR_COUNT_DEF;
   localparam int ITEM_GOAL   = 1750;
   localparam int CALM_TAIL   = 200;
   localparam int DRAIN_EVERY = 600;

   // How the first byte of a frame sets frame_start
   localparam int LEAD_NONE   = 0;
   localparam int LEAD_ALWAYS = 1;
   localparam int LEAD_RANDOM = 2;

   typedef struct packed {
      logic              drain;
      mffd_pkg::req_type item;
   } queued_req_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mffd_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mffd_pkg::rsp_type rsp_data;

   // Predicted decoder state
   logic [3:0]         rx_pos;
   logic [7:0]         rx_frame [0:10];
   logic signed [15:0] speed_mem [0:NUM_MOTORS-1];
   logic [15:0]        current_mem [0:NUM_MOTORS-1];
   logic [7:0]         status_mem [0:NUM_MOTORS-1];
   logic [7:0]         flags_mem [0:NUM_MOTORS-1];
   logic signed [31:0] ticks_mem [0:NUM_MOTORS-1];

   mffd_pkg::rsp_type replies_due [$];
   queued_req_type    req_backlog [$];

   // Frame under construction and byte position as the generator sees it
   logic [7:0] frame_buf [0:10];
   int         gen_pos    = 0;
   int         mismatches = 0;
   logic       req_fire   = 1'b0;
   int         gap_left   = 0;
   int         stall_left = 0;

   motor_feedback_frame_decoder_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #1 clock = ~clock;

   // Fill in the stored feedback of one motor, zero when out of range
   function automatic mffd_pkg::rsp_type with_stored(input mffd_pkg::rsp_type o,
                                                     input logic [7:0] id);
      if (id < NUM_MOTORS) begin
         o.speed       = speed_mem[id];
         o.current     = current_mem[id];
         o.status_byte = status_mem[id];
         o.flags_byte  = flags_mem[id];
         o.ticks       = ticks_mem[id];
      end
      return o;
   endfunction

   // Advance the predicted decoder by one transfer and queue the reply it causes
   task automatic decode_request(input mffd_pkg::req_type r);
      mffd_pkg::rsp_type o;
      logic [7:0]        sum;
      logic [7:0]        id;
      logic [7:0]        cmd;
      o = '0;
      if (r.kind == mffd_pkg::KIND_READ) begin
         o.result_kind = mffd_pkg::KIND_READ;
         o.motor_id    = {6'd0, r.motor_sel};
         replies_due.push_back(with_stored(o, o.motor_id));
      end else begin
         if (r.frame_start || rx_pos >= mffd_pkg::FRAME_LEN) rx_pos = '0;
         rx_frame[rx_pos] = r.rx_byte;
         rx_pos = rx_pos + 4'd1;
         if (rx_pos == mffd_pkg::FRAME_LEN) begin
            rx_pos = '0;
            id  = rx_frame[2];
            cmd = rx_frame[4];
            sum = rx_frame[2] + rx_frame[3] + rx_frame[4] + rx_frame[5] +
                  rx_frame[7] + rx_frame[8] + rx_frame[9] + rx_frame[10];
            o.result_kind = mffd_pkg::KIND_FRAME;
            o.motor_id    = id;
            o.command     = cmd;
            if (rx_frame[0] != mffd_pkg::PREAMBLE_0 ||
                rx_frame[1] != mffd_pkg::PREAMBLE_1) begin
               o.frame_status = mffd_pkg::ST_PREAMBLE;
            end else if ({1'b0, sum[6:0]} != rx_frame[6]) begin
               o.frame_status = mffd_pkg::ST_CHECKSUM;
            end else if (id >= NUM_MOTORS) begin
               o.frame_status = mffd_pkg::ST_MOTOR_ID;
            end else begin
               o.frame_status = mffd_pkg::ST_APPLIED;
               case (cmd)
                  mffd_pkg::CMD_SPEED: begin
                     speed_mem[id]   = {rx_frame[7], rx_frame[9]};
                     current_mem[id] = {rx_frame[3], rx_frame[5]};
                     status_mem[id]  = rx_frame[10];
                     flags_mem[id]   = rx_frame[8];
                  end
                  mffd_pkg::CMD_STATUS: begin
                     speed_mem[id]  = '0;
                     status_mem[id] = rx_frame[10];
                     flags_mem[id]  = rx_frame[8];
                  end
                  mffd_pkg::CMD_TICKS: begin
                     ticks_mem[id] = {rx_frame[3], rx_frame[5], rx_frame[7], rx_frame[9]};
                  end
                  default: o.frame_status = mffd_pkg::ST_IGNORED;
               endcase
            end
            replies_due.push_back(with_stored(o, id));
         end
      end
   endtask

   // Queue one received byte; don't-care fields get random values
   task automatic queue_byte(input logic [7:0] b, input logic start);
      queued_req_type q;
      q                  = '0;
      q.item.kind        = mffd_pkg::KIND_FRAME;
      q.item.rx_byte     = b;
      q.item.frame_start = start;
      q.item.motor_sel   = 2'($urandom);
      req_backlog.push_back(q);
      if (start || gen_pos >= mffd_pkg::FRAME_LEN) gen_pos = 0;
      gen_pos = gen_pos + 1;
      if (gen_pos == mffd_pkg::FRAME_LEN) gen_pos = 0;
   endtask

   task automatic queue_read(input logic [1:0] sel);
      queued_req_type q;
      q                  = '0;
      q.item.kind        = mffd_pkg::KIND_READ;
      q.item.rx_byte     = 8'($urandom);
      q.item.frame_start = 1'($urandom);
      q.item.motor_sel   = sel;
      req_backlog.push_back(q);
   endtask

   // Recompute the check byte of the frame buffer
   task automatic seal_frame();
      logic [7:0] sum;
      sum = frame_buf[2] + frame_buf[3] + frame_buf[4] + frame_buf[5] +
            frame_buf[7] + frame_buf[8] + frame_buf[9] + frame_buf[10];
      frame_buf[6] = {1'b0, sum[6:0]};
   endtask

   task automatic build_frame(input logic [7:0] id, input logic [7:0] cmd);
      frame_buf[0] = mffd_pkg::PREAMBLE_0;
      frame_buf[1] = mffd_pkg::PREAMBLE_1;
      frame_buf[2] = id;
      frame_buf[4] = cmd;
      frame_buf[3] = 8'($urandom);
      frame_buf[5] = 8'($urandom);
      for (int i = 7; i < 11; i++) frame_buf[i] = 8'($urandom);
      seal_frame();
   endtask

   // Queue the first len bytes of the buffer, with reads mixed in
   task automatic send_frame(input int len, input int read_pct, input int lead);
      logic start;
      for (int i = 0; i < len; i++) begin
         if (read_pct > 0 && $urandom_range(0, 99) < read_pct) queue_read(2'($urandom));
         start = 1'b0;
         if (i == 0) begin
            start = (gen_pos != 0) || (lead == LEAD_ALWAYS) ||
                    (lead == LEAD_RANDOM && $urandom_range(0, 3) != 0);
         end
         queue_byte(frame_buf[i], start);
      end
   endtask

   // Driver: present the next transfer once the current one is gone
   always @(negedge clock) begin : drive_req
      queued_req_type head;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (req_backlog.size() == 0 ||
                      (req_backlog[0].drain && replies_due.size() != 0)) begin
            req_valid <= 1'b0;
         end else begin
            head = req_backlog.pop_front();
            req_data  <= head.item;
            req_valid <= 1'b1;
            if (req_backlog.size() >= CALM_TAIL && $urandom_range(0, 9) == 0)
               gap_left = $urandom_range(1, 18);
         end
      end
   end

   // Receiver: stall the result channel in random bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (req_backlog.size() >= CALM_TAIL && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check each result transfer, then predict from each request transfer
   always @(posedge clock) begin : watch
      mffd_pkg::rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
         rx_pos = '0;
         for (int i = 0; i < 11; i++) rx_frame[i] = '0;
         for (int m = 0; m < NUM_MOTORS; m++) begin
            speed_mem[m]   = '0;
            current_mem[m] = '0;
            status_mem[m]  = '0;
            flags_mem[m]   = '0;
            ticks_mem[m]   = '0;
         end
      end else begin
         req_fire <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               mismatches = mismatches + 1;
               if (mismatches <= 10) $display("unexpected result %h", rsp_data);
            end else begin
               want = replies_due.pop_front();
               if (rsp_data.result_kind  !== want.result_kind  ||
                   rsp_data.frame_status !== want.frame_status ||
                   rsp_data.motor_id     !== want.motor_id     ||
                   rsp_data.command      !== want.command      ||
                   rsp_data.speed        !== want.speed        ||
                   rsp_data.current      !== want.current      ||
                   rsp_data.status_byte  !== want.status_byte  ||
                   rsp_data.flags_byte   !== want.flags_byte   ||
                   rsp_data.ticks        !== want.ticks) begin
                  mismatches = mismatches + 1;
                  if (mismatches <= 10) begin
                     $display("mismatch want: kind %0d st %0d id %h cmd %h spd %h cur %h",
                              want.result_kind, want.frame_status, want.motor_id,
                              want.command, want.speed, want.current);
                     $display("               sts %h flg %h tck %h",
                              want.status_byte, want.flags_byte, want.ticks);
                     $display("         got:  kind %0d st %0d id %h cmd %h spd %h cur %h",
                              rsp_data.result_kind, rsp_data.frame_status, rsp_data.motor_id,
                              rsp_data.command, rsp_data.speed, rsp_data.current);
                     $display("               sts %h flg %h tck %h",
                              rsp_data.status_byte, rsp_data.flags_byte, rsp_data.ticks);
                  end
               end
            end
         end
         if (req_valid && !req_stall) decode_request(req_data);
      end
   end

   // Stimulus and end of run
   initial begin
      int             pick;
      int             spot;
      int             chunk_at;
      int             next_drain;
      logic [7:0]     id;
      logic [7:0]     cmd;
      queued_req_type marked;

      // Reads of the cleared store
      for (int m = 0; m < 4; m++) queue_read(2'(m));
      // Speed reply with extreme content, reads mixed in
      build_frame(8'd0, mffd_pkg::CMD_SPEED);
      frame_buf[3] = 8'hFF; frame_buf[5] = 8'hFF; frame_buf[7] = 8'h80;
      frame_buf[9] = 8'h00; frame_buf[8] = 8'hFF; frame_buf[10] = 8'h00;
      seal_frame();
      send_frame(11, 20, LEAD_ALWAYS);
      // Ticks reply to the last motor, started without frame_start
      build_frame(8'd3, mffd_pkg::CMD_TICKS);
      frame_buf[3] = 8'h80; frame_buf[5] = 8'h00; frame_buf[7] = 8'h00; frame_buf[9] = 8'h01;
      seal_frame();
      send_frame(11, 0, LEAD_NONE);
      // Speed then status reply to one motor: status zeroes speed
      build_frame(8'd1, mffd_pkg::CMD_SPEED);
      send_frame(11, 0, LEAD_ALWAYS);
      build_frame(8'd1, mffd_pkg::CMD_STATUS);
      send_frame(11, 0, LEAD_NONE);
      // Unknown command
      build_frame(8'd2, 8'h55);
      send_frame(11, 0, LEAD_ALWAYS);
      // Bad preamble
      build_frame(8'd2, mffd_pkg::CMD_SPEED);
      frame_buf[0] = 8'hD4;
      send_frame(11, 0, LEAD_ALWAYS);
      // Check byte with its top bit set
      build_frame(8'd2, mffd_pkg::CMD_SPEED);
      frame_buf[6] = frame_buf[6] | 8'h80;
      send_frame(11, 0, LEAD_ALWAYS);
      // Motor id out of range
      build_frame(8'hFF, mffd_pkg::CMD_SPEED);
      send_frame(11, 0, LEAD_ALWAYS);
      // All three faults at once: preamble wins
      build_frame(8'd9, mffd_pkg::CMD_TICKS);
      frame_buf[1] = 8'h00;
      frame_buf[6] = frame_buf[6] ^ 8'h01;
      send_frame(11, 0, LEAD_ALWAYS);
      // Restart in the middle of a frame
      build_frame(8'd3, mffd_pkg::CMD_SPEED);
      send_frame(5, 0, LEAD_ALWAYS);
      build_frame(8'd2, mffd_pkg::CMD_SPEED);
      send_frame(11, 0, LEAD_ALWAYS);
      for (int m = 0; m < 4; m++) queue_read(2'(m));

      // Random traffic, mostly well-formed frames
      next_drain = DRAIN_EVERY;
      while (req_backlog.size() < ITEM_GOAL) begin
         chunk_at = req_backlog.size();
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            id = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                 8'($urandom_range(0, NUM_MOTORS - 1));
            case ($urandom_range(0, 3))
               0:       cmd = mffd_pkg::CMD_SPEED;
               1:       cmd = mffd_pkg::CMD_STATUS;
               2:       cmd = mffd_pkg::CMD_TICKS;
               default: cmd = 8'($urandom);
            endcase
            build_frame(id, cmd);
            send_frame(11, 8, LEAD_RANDOM);
         end else if (pick < 72) begin
            repeat ($urandom_range(1, 4)) queue_read(2'($urandom));
         end else if (pick < 84) begin
            // Corrupt one bit of an otherwise valid frame, at times also setting the check byte's top bit
            build_frame(8'($urandom_range(0, NUM_MOTORS - 1)), mffd_pkg::CMD_SPEED);
            spot = $urandom_range(0, 10);
            frame_buf[spot] = frame_buf[spot] ^ (8'd1 << $urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0) frame_buf[6] = frame_buf[6] | 8'h80;
            send_frame(11, 8, LEAD_RANDOM);
         end else if (pick < 93) begin
            build_frame(8'($urandom_range(0, NUM_MOTORS - 1)), mffd_pkg::CMD_TICKS);
            send_frame($urandom_range(1, 10), 8, LEAD_RANDOM);
         end else begin
            repeat ($urandom_range(1, 6)) queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
         end
         // Hold the sender until the block has drained
         if (chunk_at >= next_drain && req_backlog.size() > chunk_at) begin
            marked = req_backlog[chunk_at];
            marked.drain = 1'b1;
            req_backlog[chunk_at] = marked;
            next_drain = next_drain + DRAIN_EVERY;
         end
      end

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #800000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
